@@ rtl/core/ramb_pkg.sv @@
// ---------------------------------------------------------------------------
// ramb_pkg
// Shared types and constants of the route adjacency matrix builder.
// ---------------------------------------------------------------------------
package ramb_pkg;

  // stream word layout
  localparam int SDATA_W   = 16;  // stop_number, row_index, zero fill
  localparam int SUSER_W   = 2;   // opcode, matrix_select
  localparam int MDATA_W   = 40;  // row_bits, row_echo, zero fill
  localparam int STOP_W    = 6;
  localparam int STOP_LSB  = 0;
  localparam int ROW_W     = 5;
  localparam int ROW_LSB   = 6;
  localparam int OPC_BIT   = 0;
  localparam int SEL_BIT   = 1;
  localparam int ROWBITS_W = 32;
  localparam int NODE_W    = 6;
  localparam int LIM_W     = 7;   // limit up to 63

  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 6'd32;

  localparam logic OPC_STOP = 1'b0;
  localparam logic OPC_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_LOAD
  } ramb_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;      // word accepted, latch fields
    logic sweep;     // row sweep step
    logic finish;    // last sweep step, update route state
    logic load_out;  // load output register
  } ramb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_read;     // incoming word is a row read
    logic in_stop_ok;  // incoming stop is within the limit
    logic sweep_last;  // sweep counter at its final step
    logic out_free;    // output register can take a word
  } ramb_sts_t;

endpackage

@@ rtl/core/ramb_ram.sv @@
// ---------------------------------------------------------------------------
// ramb_ram
// Generic simple dual-port RAM, one write port, registered read.
// ---------------------------------------------------------------------------
module ramb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ramb_ctrl.sv @@
// ---------------------------------------------------------------------------
// ramb_ctrl
// Sequencer: accepts words, runs the row sweep, the row read and the
// output load.
// ---------------------------------------------------------------------------
module ramb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  ramb_pkg::ramb_sts_t sts,
  output ramb_pkg::ramb_cmd_t cmd
);
  import ramb_pkg::*;

  ramb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take = 1'b1;
          if (sts.in_read) begin
            state_next = ST_READ;
          end else if (sts.in_stop_ok) begin
            state_next = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/ramb_dpath.sv @@
// ---------------------------------------------------------------------------
// ramb_dpath
// Datapath: matrix RAMs with row valid bits, route state, sweep counter,
// node count register and output register.
// ---------------------------------------------------------------------------
module ramb_dpath #(
  parameter int MAX_NODES = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ramb_pkg::NODE_W-1:0]      cfg_wdata,
  input  logic [ramb_pkg::SDATA_W-1:0]     s_tdata,
  input  logic [ramb_pkg::SUSER_W-1:0]     s_tuser,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ramb_pkg::MDATA_W-1:0]     m_tdata,
  input  ramb_pkg::ramb_cmd_t              cmd,
  output ramb_pkg::ramb_sts_t              sts
);
  import ramb_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [LIM_W-1:0] MAX_L = LIM_W'(MAX_NODES);
  localparam logic [CW-1:0]    LAST_CNT = CW'(MAX_NODES);

  // configuration and route state
  logic [NODE_W-1:0]    node_count;
  logic [MAX_NODES-1:0] members;
  logic [AW-1:0]        prev_stop;
  logic                 route_open;
  logic [MAX_NODES-1:0] row_valid;
  logic [CW-1:0]        cnt;

  // latched word
  logic [AW-1:0]    stop_q;
  logic [ROW_W-1:0] row_q;
  logic             sel_q;
  logic             end_q;

  // RAM side
  logic [AW-1:0]        raddr, waddr;
  logic                 we;
  logic [MAX_NODES-1:0] rd_c, rd_s, cur_c, cur_s, new_c, new_s;
  logic                 rd_ok;

  logic [LIM_W-1:0]     lim;
  logic [STOP_W-1:0]    in_stop;
  logic                 in_stop_ok;
  logic [MAX_NODES-1:0] sbit, pbit, col_mask, row_sel;
  logic                 row_hit;
  logic [ROWBITS_W-1:0] row_bits;

  assign in_stop = s_tdata[STOP_LSB +: STOP_W];
  assign lim = ({1'b0, node_count} > MAX_L) ? MAX_L : {1'b0, node_count};
  assign in_stop_ok = (in_stop != '0) && ({1'b0, in_stop} <= lim);

  assign sts.in_read    = (s_tuser[OPC_BIT] == OPC_READ);
  assign sts.in_stop_ok = in_stop_ok;
  assign sts.sweep_last = (cnt == LAST_CNT);
  assign sts.out_free   = !m_tvalid || m_tready;

  // sweep reads row cnt and writes back row cnt-1
  assign raddr = cmd.sweep ? cnt[AW-1:0] : AW'(row_q);
  assign waddr = AW'(cnt - CW'(1));
  assign we    = cmd.sweep && (cnt != '0);

  assign cur_c = rd_ok ? rd_c : '0;
  assign cur_s = rd_ok ? rd_s : '0;
  assign sbit  = MAX_NODES'(1) << stop_q;
  assign pbit  = MAX_NODES'(1) << prev_stop;

  always_comb begin
    new_c = cur_c;
    new_s = cur_s;
    if (route_open && (waddr == prev_stop)) begin
      new_c = new_c | sbit;
    end
    if (route_open && (waddr == stop_q)) begin
      new_c = new_c | pbit;
    end
    if (members[waddr]) begin
      new_s = new_s | sbit;
    end
    if (waddr == stop_q) begin
      new_s = new_s | members;
    end
  end

  ramb_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_consec_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (new_c),
    .raddr (raddr),
    .rdata (rd_c)
  );

  ramb_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_same_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (new_s),
    .raddr (raddr),
    .rdata (rd_s)
  );

  // read path: mask columns to the limit
  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      col_mask[j] = (LIM_W'(j) < lim);
    end
  end

  assign row_hit  = ({2'b00, row_q} < lim);
  assign row_sel  = (sel_q ? cur_s : cur_c) & col_mask;
  assign row_bits = row_hit ? ROWBITS_W'(row_sel) : '0;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
      members    <= '0;
      prev_stop  <= '0;
      route_open <= 1'b0;
      row_valid  <= '0;
      cnt        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      if (cmd.take) begin
        cnt <= '0;
        if ((s_tuser[OPC_BIT] == OPC_STOP) && !in_stop_ok && s_tlast) begin
          members    <= '0;
          route_open <= 1'b0;
        end
      end
      if (cmd.sweep) begin
        cnt <= cnt + CW'(1);
      end
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      if (cmd.finish) begin
        prev_stop  <= stop_q;
        route_open <= !end_q;
        members    <= end_q ? '0 : (members | sbit);
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rd_ok <= (32'(raddr) < MAX_NODES) ? row_valid[raddr] : 1'b0;
    if (cmd.take) begin
      stop_q <= AW'(in_stop - STOP_W'(1));
      row_q  <= s_tdata[ROW_LSB +: ROW_W];
      sel_q  <= s_tuser[SEL_BIT];
      end_q  <= s_tlast;
    end
    if (cmd.load_out) begin
      m_tdata <= {3'b000, row_q, row_bits};
    end
  end

endmodule

@@ rtl/core/route_adjacency_matrix_builder_unit.sv @@
// ---------------------------------------------------------------------------
// route_adjacency_matrix_builder_unit
// Builds consecutive-stop and same-route adjacency matrices from a stream
// of route stops and returns single matrix rows on request.
// ---------------------------------------------------------------------------
// Takes one word at a time. A stop word (opcode 0) within the node limit
// is accepted, then a sweep walks every row of both matrix RAMs through
// their single read and write ports, reading row k while writing back row
// k-1 with the new column bits. A stop of zero or above the limit (the
// smaller of node_count and MAX_NODES) runs no sweep; only its route_end
// flag acts. A read word (opcode 1) passes through accept, RAM read and
// output load, the load waiting for the output register to empty; the
// next word can be taken while the result still sits in the output
// register. Both matrices read as zero after reset through per-row valid
// bits, so no clearing pass is needed. node_count is to be written through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module route_adjacency_matrix_builder_unit #(
  parameter int MAX_NODES = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration: node_count
  input  logic                         cfg_we,
  input  logic [ramb_pkg::NODE_W-1:0]  cfg_wdata,
  // input words
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ramb_pkg::SDATA_W-1:0] s_tdata,  // [5:0] stop_number, [10:6] row_index
  input  logic [ramb_pkg::SUSER_W-1:0] s_tuser,  // [0] opcode, [1] matrix_select
  input  logic                         s_tlast,  // route_end
  // result words
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ramb_pkg::MDATA_W-1:0] m_tdata   // [31:0] row_bits, [36:32] row_echo
);
  import ramb_pkg::*;

  ramb_cmd_t cmd;
  ramb_sts_t sts;

  // sequencer
  ramb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // matrices, route state and output register
  ramb_dpath #(.MAX_NODES(MAX_NODES)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ rtl/core/ramb_checker.sv @@
// ---------------------------------------------------------------------------
// ramb_checker
// Port-level checks of the route adjacency matrix builder.
// ---------------------------------------------------------------------------
module ramb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [ramb_pkg::SDATA_W-1:0] s_tdata,
  input logic [ramb_pkg::SUSER_W-1:0] s_tuser,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [ramb_pkg::MDATA_W-1:0] m_tdata
);
  import ramb_pkg::*;

  logic rd_acc;
  assign rd_acc = s_tvalid && s_tready && (s_tuser[OPC_BIT] == OPC_READ);

  a_rst_clear: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    rd_acc |=> !s_tready)
    else $error("word taken during row read");

  // accept, RAM read, output load: a newly valid word stems from a row read
  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(rd_acc, 3) &&
      (m_tdata[ROWBITS_W +: ROW_W] == $past(s_tdata[ROW_LSB +: ROW_W], 3)))
    else $error("result word not from the last row read");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    rd_acc && !m_tvalid |=> ##2 m_tvalid)
    else $error("row read result late");

endmodule

bind route_adjacency_matrix_builder_unit ramb_checker u_ramb_checker (.*);

@@ sim/ramb_row_checker.sv @@
// ----------------------------------------------------------------------------
// ramb_row_checker
// Watches the config, input and result channels of the matrix builder,
// keeps its own copy of both adjacency matrices and the open route, and
// checks each returned row word against the oldest outstanding read.
// ----------------------------------------------------------------------------
module ramb_row_checker #(
  parameter int MAX_NODES = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ramb_pkg::NODE_W-1:0]  cfg_wdata,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [ramb_pkg::SDATA_W-1:0] s_tdata,
  input  logic [ramb_pkg::SUSER_W-1:0] s_tuser,
  input  logic                         s_tlast,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [ramb_pkg::MDATA_W-1:0] m_tdata,
  output int                           fail_count,
  output int                           rows_due_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ramb_pkg::*;

  typedef struct packed {
    logic [ROWBITS_W-1:0] bits;
    logic [ROW_W-1:0]     echo;
  } row_word_t;

  logic [ROWBITS_W-1:0] hop_rows  [MAX_NODES];  // consecutive stops
  logic [ROWBITS_W-1:0] tour_rows [MAX_NODES];  // same route
  logic [ROWBITS_W-1:0] members;
  int unsigned          last_stop;
  bit                   route_live;
  logic [NODE_W-1:0]    nodes;
  row_word_t            rows_due [$];
  int                   fails = 0;

  function automatic int unsigned node_limit();
    return (nodes > MAX_NODES) ? MAX_NODES : nodes;
  endfunction

  function automatic void clear_state();
    for (int i = 0; i < MAX_NODES; i++) begin
      hop_rows[i]  = '0;
      tour_rows[i] = '0;
    end
    members    = '0;
    last_stop  = 0;
    route_live = 1'b0;
    nodes      = NODE_COUNT_RST;
    rows_due.delete();
  endfunction

  function automatic void add_stop(int unsigned s);
    if (route_live && last_stop < MAX_NODES) begin
      hop_rows[last_stop][s] = 1'b1;
      hop_rows[s][last_stop] = 1'b1;
    end
    for (int m = 0; m < MAX_NODES; m++) begin
      if (members[m]) begin
        tour_rows[m][s] = 1'b1;
        tour_rows[s][m] = 1'b1;
      end
    end
    members[s] = 1'b1;
    last_stop  = s;
    route_live = 1'b1;
  endfunction

  // update the matrices for one accepted word; queue a row if it is a read
  function automatic void apply_word(logic [SDATA_W-1:0] data, logic [SUSER_W-1:0] user,
                                     logic route_end);
    int unsigned          lim;
    int unsigned          stop;
    int unsigned          row;
    row_word_t            want;
    lim  = node_limit();
    stop = data[STOP_LSB +: STOP_W];
    row  = data[ROW_LSB +: ROW_W];
    if (user[OPC_BIT] == OPC_STOP) begin
      if (stop >= 1 && stop <= lim)
        add_stop(stop - 1);
      if (route_end) begin
        members    = '0;
        route_live = 1'b0;
      end
    end else begin
      want.bits = '0;
      want.echo = ROW_W'(row);
      if (row < lim) begin
        want.bits = user[SEL_BIT] ? tour_rows[row] : hop_rows[row];
        if (lim < ROWBITS_W)
          want.bits &= (ROWBITS_W'(1) << lim) - ROWBITS_W'(1);
      end
      rows_due.push_back(want);
    end
  endfunction

  always @(posedge clk) begin
    row_word_t want;
    if (rst) begin
      clear_state();
    end else begin
      // results first: they always belong to an older read
      if (m_tvalid && m_tready) begin
        if (rows_due.size() == 0) begin
          $error("result word with no read outstanding: %h", m_tdata);
          fails++;
        end else begin
          want = rows_due.pop_front();
          if (m_tdata[ROWBITS_W-1:0] !== want.bits) begin
            $error("row_bits: expected %h, got %h", want.bits, m_tdata[ROWBITS_W-1:0]);
            fails++;
          end
          if (m_tdata[ROWBITS_W +: ROW_W] !== want.echo) begin
            $error("row_echo: expected %0d, got %0d", want.echo, m_tdata[ROWBITS_W +: ROW_W]);
            fails++;
          end
          if (m_tdata[MDATA_W-1:ROWBITS_W+ROW_W] !== '0) begin
            $error("zero_fill: expected 0, got %h", m_tdata[MDATA_W-1:ROWBITS_W+ROW_W]);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready)
        apply_word(s_tdata, s_tuser, s_tlast);
      if (cfg_we)
        nodes = cfg_wdata;
    end
    fail_count     <= fails;
    rows_due_count <= rows_due.size();
  end

endmodule

@@ sim/tb_route_adjacency_matrix_builder_unit.sv @@
// ----------------------------------------------------------------------------
// tb_route_adjacency_matrix_builder_unit
// Drives routes and row reads into the matrix builder under varying node
// counts and back-pressure; a separate checker predicts every row word.
// ----------------------------------------------------------------------------
module tb_route_adjacency_matrix_builder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ramb_pkg::*;

  localparam int MAX_NODES   = 32;
  localparam int BUSY_CYCLES = MAX_NODES + 8;  // outlasts a stop sweep
  localparam int HOLD_CYCLES = 300;            // long receiver hold-off
  localparam int LIMIT       = 400000;         // run-away guard, in clock cycles

  logic               clk;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [NODE_W-1:0]  cfg_wdata = '0;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [SDATA_W-1:0] s_tdata   = '0;  // [5:0] stop_number, [10:6] row_index
  logic [SUSER_W-1:0] s_tuser   = '0;  // [0] opcode, [1] matrix_select
  logic               s_tlast   = 1'b0; // route_end
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [MDATA_W-1:0] m_tdata;          // [31:0] row_bits, [36:32] row_echo

  int  fail_count;
  int  rows_due_count;
  int  send_idle = 0;   // percent of cycles the sender sits out
  int  recv_idle = 0;   // percent of cycles the receiver holds off
  bit  hold_req  = 1'b0;
  int  hold_left = 0;
  int  cycles    = 0;
  int  cur_nodes = NODE_COUNT_RST;  // mirror of node_count, only to shape stimulus
  logic [STOP_W-1:0] prev_pick = '0;

  route_adjacency_matrix_builder_unit #(
    .MAX_NODES (MAX_NODES)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  ramb_row_checker #(
    .MAX_NODES (MAX_NODES)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .fail_count     (fail_count),
    .rows_due_count (rows_due_count)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random idling, plus a long hold-off on request. The hold is
  // counted here so the sender keeps offering words meanwhile.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // One word onto the input channel. Called at a clock edge; returns at the
  // edge where the word was taken, leaving tvalid high so back-to-back words
  // need no gap.
  task automatic send_word(input logic opc, input logic [STOP_W-1:0] stop,
                           input logic route_end, input logic [ROW_W-1:0] row,
                           input logic sel);
    logic [SDATA_W-1:0] data;
    logic [SUSER_W-1:0] user;
    data = '0;
    user = '0;
    data[STOP_LSB +: STOP_W] = stop;
    data[ROW_LSB +: ROW_W]   = row;
    user[OPC_BIT]            = opc;
    user[SEL_BIT]            = sel;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= user;
    s_tlast  <= route_end;
    do @(posedge clk); while (!s_tready);
  endtask

  // the unused fields of each word carry random bits
  task automatic send_stop(input logic [STOP_W-1:0] stop, input logic route_end);
    send_word(OPC_STOP, stop, route_end, ROW_W'($urandom_range(31)), 1'($urandom_range(1)));
  endtask

  task automatic send_read(input logic [ROW_W-1:0] row, input logic sel);
    send_word(OPC_READ, STOP_W'($urandom_range(63)), 1'($urandom_range(1)), row, sel);
  endtask

  // Drop tvalid, let every outstanding row come back and the last stop
  // sweep finish, then write node_count.
  task automatic set_nodes(input logic [NODE_W-1:0] value);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (rows_due_count != 0);
    repeat (BUSY_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_nodes = int'(value);
  endtask

  // mostly stops inside the limit; some repeats, some out of range
  function automatic logic [STOP_W-1:0] pick_stop();
    int lim;
    lim = (cur_nodes > MAX_NODES) ? MAX_NODES : cur_nodes;
    if (lim == 0 || $urandom_range(99) < 12)
      return STOP_W'($urandom_range(63));
    if ($urandom_range(99) < 10)
      return prev_pick;
    return STOP_W'($urandom_range(lim, 1));
  endfunction

  function automatic logic [ROW_W-1:0] pick_row();
    int lim;
    lim = (cur_nodes > MAX_NODES) ? MAX_NODES : cur_nodes;
    if (lim == 0 || $urandom_range(99) < 20)
      return ROW_W'($urandom_range(31));
    return ROW_W'($urandom_range(lim - 1, 0));
  endfunction

  // Random routes of 1..8 stops, each closed by route_end unless n_words
  // runs out first, with reads scattered between the stops.
  task automatic run_routes(input int n_words);
    int sent;
    int len;
    sent = 0;
    while (sent < n_words) begin
      len = $urandom_range(8, 1);
      for (int k = 0; k < len && sent < n_words; k++) begin
        if ($urandom_range(99) < 30) begin
          send_read(pick_row(), 1'($urandom_range(1)));
          sent++;
        end
        prev_pick = pick_stop();
        send_stop(prev_pick, k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 37;
    recv_idle = 48;

    // --- directed: node_count at its reset value
    send_stop(6'd1, 1'b0);
    send_stop(6'd32, 1'b0);
    send_stop(6'd5, 1'b0);
    send_stop(6'd5, 1'b0);   // repeat within route: diagonal bits
    send_stop(6'd0, 1'b0);   // stop zero, ignored
    send_stop(6'd33, 1'b0);  // above the limit, ignored
    send_stop(6'd63, 1'b1);  // ignored, but still closes the route
    send_stop(6'd7, 1'b1);   // lone stop, no bits
    send_stop(6'd2, 1'b0);
    send_stop(6'd2, 1'b1);
    send_read(5'd0, 1'b0);
    send_read(5'd31, 1'b1);
    send_read(5'd4, 1'b1);
    send_read(5'd4, 1'b0);
    send_read(5'd1, 1'b0);
    send_read(5'd6, 1'b1);

    // node_count zero: stops ignored, reads all zero
    set_nodes(6'd0);
    send_stop(6'd1, 1'b0);
    send_stop(6'd2, 1'b1);
    send_read(5'd0, 1'b1);
    send_read(5'd0, 1'b0);

    // node_count above MAX_NODES clamps; then shrink it mid-route
    set_nodes(6'd63);
    send_stop(6'd3, 1'b0);
    send_stop(6'd10, 1'b0);
    set_nodes(6'd4);
    send_stop(6'd10, 1'b0);  // now out of range, route stays open
    send_stop(6'd2, 1'b1);
    send_read(5'd2, 1'b1);   // row masked to four columns
    send_read(5'd31, 1'b1);  // row beyond the limit

    // --- random, sender 37 % idle, receiver 48 %
    set_nodes(6'd32);
    run_routes(125);
    set_nodes(NODE_W'($urandom_range(31, 2)));
    run_routes(125);

    // --- random, roles swapped
    send_idle = 48;
    recv_idle = 37;
    set_nodes(6'd1);
    run_routes(60);
    set_nodes(NODE_W'($urandom_range(20, 5)));
    run_routes(190);

    // --- random, no idling; open with a long receiver hold-off so reads
    // back up and the input stalls
    send_idle = 0;
    recv_idle = 0;
    set_nodes(6'd32);
    hold_req = 1'b1;
    repeat (24) send_read(pick_row(), 1'($urandom_range(1)));
    run_routes(100);
    set_nodes(NODE_W'($urandom_range(63, 33)));
    run_routes(110);

    // drain
    s_tvalid <= 1'b0;
    do @(posedge clk); while (rows_due_count != 0);
    repeat (BUSY_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
